// File: rtl/core/mono_pixel_packer_lcd_writer_assert.svh
`ifndef MONO_PIXEL_PACKER_LCD_WRITER_ASSERT_SVH
`define MONO_PIXEL_PACKER_LCD_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define MPP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = 1;

	localparam logic [ADDR_W-1:0] GRAPHIC_BASE_RST = 16'h0000;
	localparam logic [BYTE_W-1:0] SET_ADDR_OPC_RST = 8'd36;
	localparam logic [BYTE_W-1:0] WRITE_OPC_RST    = 8'd192;
	localparam logic [BYTE_W-1:0] MSB_MASK         = 8'h80;
	localparam logic [2:0]        LAST_BIT_POS     = 3'd7;
	localparam logic [2:0]        FIRST_BIT_POS    = 3'd0;

	typedef enum logic [1:0] {
		CFG_GRAPHIC_BASE = 2'd0,
		CFG_SET_ADDR_OPC = 2'd1,
		CFG_WRITE_OPC    = 2'd2
	} cfg_index_t;

	// One write request queued between front and back.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
		logic              set_addr;
	} mpp_entry_t;

	typedef struct packed {
		logic [BYTE_W-1:0] set_addr;
		logic [BYTE_W-1:0] write_data;
	} mpp_opc_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ADDR_LO,
		BK_ADDR_HI,
		BK_SET_CMD,
		BK_DATA,
		BK_WR_CMD
	} bk_state_t;

endpackage
`default_nettype wire

// File: rtl/core/mpp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mpp_front import mpp_pkg::*; #(
	parameter int WIDTH_PIXELS = 240
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        pixel_x,
	input  wire logic [6:0]        pixel_y,
	input  wire logic              is_black,
	input  wire logic              flush,
	input  wire logic [ADDR_W-1:0] graphic_base,
	input  wire logic              q_ready,
	output logic                   q_push,
	output mpp_entry_t             q_entry
);

	localparam int LIN_W = $clog2(255 + 127 * WIDTH_PIXELS + 1);

	logic              v_s1;
	logic [7:0]        px_s1;
	logic [6:0]        py_s1;
	logic              black_s1;
	logic              flush_s1;
	logic [BYTE_W-1:0] pending_q;
	logic [ADDR_W-1:0] cached_q;

	logic [LIN_W-1:0]  linear;
	logic [2:0]        bitpos;
	logic [BYTE_W-1:0] mask;
	logic [BYTE_W-1:0] held;
	logic [BYTE_W-1:0] pending_d;
	logic [ADDR_W-1:0] addr;
	logic              emit;
	logic              need_addr;
	logic              go_s1;

	always_comb begin
		linear    = LIN_W'(px_s1) + LIN_W'(py_s1) * LIN_W'(WIDTH_PIXELS);
		bitpos    = linear[2:0];
		mask      = MSB_MASK >> bitpos;
		held      = (bitpos == FIRST_BIT_POS) ? '0 : pending_q;
		pending_d = black_s1 ? (held | mask) : (held & ~mask);
		addr      = graphic_base + ADDR_W'(linear[LIN_W-1:3]);
		emit      = (bitpos == LAST_BIT_POS) || flush_s1;
		need_addr = (addr != cached_q);
	end

	// a pixel that writes nothing never waits on the queue
	assign go_s1    = v_s1 && (!emit || q_ready);
	assign in_ready = !v_s1 || go_s1;
	assign q_push   = go_s1 && emit;
	assign q_entry  = '{addr: addr, data: pending_d, set_addr: need_addr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			pending_q <= '0;
			cached_q  <= '0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (go_s1) begin
				pending_q <= pending_d;
				if (emit && need_addr)
					cached_q <= addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_s1    <= pixel_x;
			py_s1    <= pixel_y;
			black_s1 <= is_black;
			flush_s1 <= flush;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/mpp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module mpp_fifo import mpp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire mpp_entry_t push_entry,
	output logic            push_ready,
	input  wire logic       pop,
	output logic            pop_valid,
	output mpp_entry_t      pop_entry
);

	mpp_entry_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ready = (count_q != (Q_PTR_W + 1)'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule
`default_nettype wire

// File: rtl/core/mpp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mpp_back import mpp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire mpp_entry_t         q_entry,
	output logic                    q_pop,
	input  wire mpp_opc_t           opc,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [BYTE_W-1:0]       bus_byte,
	output logic                    is_command,
	output logic                    last
);

	bk_state_t         state_q;
	bk_state_t         state_d;
	mpp_entry_t        entry_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              cmd_q;
	logic              last_q;

	logic              out_adv;
	logic              send;
	logic [BYTE_W-1:0] byte_d;
	logic              cmd_d;
	logic              last_d;

	assign out_adv = !out_valid_q || out_ready;
	assign send    = out_adv && (state_q != BK_IDLE);

	// take the next request from idle or while sending the final command
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = q_entry.set_addr ? BK_ADDR_LO : BK_DATA;
				end
			end
			BK_ADDR_LO: if (out_adv) state_d = BK_ADDR_HI;
			BK_ADDR_HI: if (out_adv) state_d = BK_SET_CMD;
			BK_SET_CMD: if (out_adv) state_d = BK_DATA;
			BK_DATA:    if (out_adv) state_d = BK_WR_CMD;
			BK_WR_CMD: begin
				if (out_adv) begin
					if (q_valid) begin
						q_pop   = 1'b1;
						state_d = q_entry.set_addr ? BK_ADDR_LO : BK_DATA;
					end else begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		byte_d = '0;
		cmd_d  = 1'b0;
		last_d = 1'b0;
		case (state_q)
			BK_ADDR_LO: byte_d = entry_q.addr[BYTE_W-1:0];
			BK_ADDR_HI: byte_d = entry_q.addr[ADDR_W-1:BYTE_W];
			BK_SET_CMD: begin
				byte_d = opc.set_addr;
				cmd_d  = 1'b1;
			end
			BK_DATA:    byte_d = entry_q.data;
			BK_WR_CMD: begin
				byte_d = opc.write_data;
				cmd_d  = 1'b1;
				last_d = 1'b1;
			end
			default: byte_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (send)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			entry_q <= q_entry;
		if (send) begin
			byte_q <= byte_d;
			cmd_q  <= cmd_d;
			last_q <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign bus_byte   = byte_q;
	assign is_command = cmd_q;
	assign last       = last_q;

endmodule
`default_nettype wire

// File: rtl/core/mono_pixel_packer_lcd_writer.sv
// A pixel that closes a byte passes the front-end register and a 2-deep queue to the byte
// sequencer, which registers its bytes onto the bus. Throughput: one pixel per cycle in; only
// a pixel that writes enters the queue or waits while it is full. The sequencer sends 5 bytes
// per write with an address reload and 2 without, one byte per cycle while out_ready is high.
// Reset (arst_n low, asynchronous) empties the pipeline and queue, clears the held byte
// and cached pointer, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "mono_pixel_packer_lcd_writer_assert.svh"
module mono_pixel_packer_lcd_writer import mpp_pkg::*; #(
	parameter int WIDTH_PIXELS = 240
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [ADDR_W-1:0]  cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         pixel_x,
	input  wire logic [6:0]         pixel_y,
	input  wire logic               is_black,
	input  wire logic               flush,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [BYTE_W-1:0]       bus_byte,
	output logic                    is_command,
	output logic                    last
);

	logic [ADDR_W-1:0] graphic_base_q;
	mpp_opc_t          opc_q;

	logic       q_push;
	logic       q_ready;
	logic       q_pop;
	logic       q_valid;
	mpp_entry_t push_entry;
	mpp_entry_t pop_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			graphic_base_q   <= GRAPHIC_BASE_RST;
			opc_q.set_addr   <= SET_ADDR_OPC_RST;
			opc_q.write_data <= WRITE_OPC_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRAPHIC_BASE: graphic_base_q   <= cfg_data;
				CFG_SET_ADDR_OPC: opc_q.set_addr   <= cfg_data[BYTE_W-1:0];
				CFG_WRITE_OPC:    opc_q.write_data <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	mpp_front #(
		.WIDTH_PIXELS(WIDTH_PIXELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.is_black    (is_black),
		.flush       (flush),
		.graphic_base(graphic_base_q),
		.q_ready     (q_ready),
		.q_push      (q_push),
		.q_entry     (push_entry)
	);

	mpp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(push_entry),
		.push_ready(q_ready),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_entry (pop_entry)
	);

	mpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (pop_entry),
		.q_pop     (q_pop),
		.opc       (opc_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bus_byte  (bus_byte),
		.is_command(is_command),
		.last      (last)
	);

	`MPP_ASSERT_NOW(a_push_not_full, q_push, q_ready, "request pushed into a full queue")
	`MPP_ASSERT_NOW(a_pop_not_empty, q_pop, q_valid, "request popped from an empty queue")
	`MPP_ASSERT_NOW(a_last_is_cmd, out_valid && last, is_command, "last byte is not a command")
	`MPP_ASSERT_NEXT(a_write_follows_data, out_valid && out_ready && !last && !is_command && !q_pop,
		out_valid || !out_ready, "byte run broken before its write command")

endmodule
`default_nettype wire
